// ===== rtl/core/prn_pkg.sv =====
// ----------------------------------------------------------------------------
// prn_pkg
// Shared constants for the priority renumbering unit: field widths, the
// default vertex limit and the mode codes.
// ----------------------------------------------------------------------------
package prn_pkg;

  localparam int MAX_VERTICES_DEF = 65536;
  localparam int PRIO_IN_W        = 31;
  localparam int KEY_W            = PRIO_IN_W + 1;
  localparam int MODE_W           = 3;

  localparam logic [MODE_W-1:0] MODE_INFLATE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_COMPRESS = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RENUMBER = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EVENODD  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MINMAX   = 3'd4;

  localparam logic [MODE_W-1:0] MODE_RESET    = MODE_RENUMBER;

endpackage

// ===== rtl/core/prn_if.sv =====
// ----------------------------------------------------------------------------
// prn_req_if / prn_res_if
// Valid/ready channels for vertex requests and renumbered results.
// ----------------------------------------------------------------------------
interface prn_req_if
  import prn_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [PRIO_IN_W-1:0] priority_req;
  logic                 owner;
  logic                 last;

  modport source (output valid, output priority_req, output owner, output last,
                  input ready);
  modport sink   (input valid, input priority_req, input owner, input last,
                  output ready);
endinterface

interface prn_res_if #(
  parameter int PRIO_W = 18,
  parameter int CNT_W  = 17
) ();
  logic              valid;
  logic              ready;
  logic [PRIO_W-1:0] new_priority;
  logic              new_owner;
  logic [CNT_W-1:0]  distinct_count;
  logic              end_of_run;

  modport source (output valid, output new_priority, output new_owner,
                  output distinct_count, output end_of_run, input ready);
  modport sink   (input valid, input new_priority, input new_owner,
                  input distinct_count, input end_of_run, output ready);
endinterface

// ===== rtl/core/priority_renumber_unit.sv =====
// ----------------------------------------------------------------------------
// priority_renumber_unit
// Dense, parity-keeping renumbering of a sorted stream of vertex priorities.
//
//   channel  | dir | payload                                       | handshake
//   ---------+-----+-----------------------------------------------+----------
//   req      | in  | priority_req[30:0], owner, last               | valid/ready
//   res      | out | new_priority, new_owner, distinct_count, eor  | valid/ready
//   cfg      | in  | cfg_wdata[2:0] (mode)                         | cfg_we
//
// One request per cycle while req.ready is high; each result is registered.
// The run state updates in the accept cycle, so the next request sees it.
// An output register plus one skid register decouple the sides: req.ready
// drops only when both hold results. rst (synchronous) clears run state,
// both buffers and sets mode to renumber.
// ----------------------------------------------------------------------------
module priority_renumber_unit
  import prn_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int PRIO_W       = $clog2(2 * MAX_VERTICES + 1),
  parameter int CNT_W        = $clog2(MAX_VERTICES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [MODE_W-1:0] cfg_wdata,
  prn_req_if.sink           req,
  prn_res_if.source         res
);

  localparam logic [PRIO_W:0]  PRIO_CAP = (PRIO_W+1)'(2 * MAX_VERTICES);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_VERTICES);

  // configuration and run state
  logic [MODE_W-1:0] mode;
  logic              started;
  logic [PRIO_W-1:0] current_priority;
  logic [KEY_W-1:0]  previous_original;
  logic [CNT_W-1:0]  distinct_counter;

  // output and skid buffers
  logic              out_valid;
  logic [PRIO_W-1:0] out_prio;
  logic              out_owner;
  logic [CNT_W-1:0]  out_cnt;
  logic              out_eor;
  logic              skid_valid;
  logic [PRIO_W-1:0] skid_prio;
  logic              skid_owner;
  logic [CNT_W-1:0]  skid_cnt;
  logic              skid_eor;

  // per-request logic
  logic              accept;
  logic              out_take;
  logic [MODE_W-1:0] mode_eff;
  logic              is_evenodd;
  logic              is_inflate;
  logic              is_compress;
  logic [KEY_W-1:0]  key;
  logic              par;
  logic [1:0]        inc;
  logic [PRIO_W:0]   sum;
  logic [PRIO_W-1:0] prio_next;
  logic [CNT_W-1:0]  cnt_next;
  logic              owner_next;

  assign accept    = req.valid && req.ready;
  assign out_take  = out_valid && res.ready;
  assign req.ready = !skid_valid;

  always_comb begin
    mode_eff    = (mode > MODE_MINMAX) ? MODE_RENUMBER : mode;
    is_evenodd  = (mode_eff == MODE_EVENODD);
    is_inflate  = (mode_eff == MODE_INFLATE);
    is_compress = (mode_eff == MODE_COMPRESS);
    key         = {1'b0, req.priority_req} + KEY_W'(is_evenodd);
    par         = key[0];
    owner_next  = req.owner ^ is_evenodd;

    if (par != current_priority[0]) begin
      inc = 2'd1;
    end else if (is_inflate) begin
      inc = 2'd2;
    end else if (is_compress) begin
      inc = 2'd0;
    end else if (key != previous_original) begin
      inc = 2'd2;
    end else begin
      inc = 2'd0;
    end

    sum = {1'b0, current_priority} + (PRIO_W+1)'(inc);

    if (!started) begin
      prio_next = PRIO_W'(par);
      cnt_next  = CNT_W'(1);
    end else begin
      // cap keeps the parity of the key
      if (sum > PRIO_CAP) begin
        prio_next = par ? PRIO_W'(PRIO_CAP - 1'b1) : PRIO_W'(PRIO_CAP);
      end else begin
        prio_next = sum[PRIO_W-1:0];
      end
      if (inc != 2'd0 && distinct_counter < CNT_MAX) begin
        cnt_next = distinct_counter + 1'b1;
      end else begin
        cnt_next = distinct_counter;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RESET;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started           <= 1'b0;
      current_priority  <= '0;
      previous_original <= '0;
      distinct_counter  <= '0;
    end else if (accept) begin
      if (req.last) begin
        started           <= 1'b0;
        current_priority  <= '0;
        previous_original <= '0;
        distinct_counter  <= '0;
      end else begin
        started           <= 1'b1;
        current_priority  <= prio_next;
        previous_original <= key;
        distinct_counter  <= cnt_next;
      end
    end
  end

  // result buffering: skid only fills while the output register is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid && out_take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (accept && out_valid && !res.ready) begin
        skid_valid <= 1'b1;
      end else if (accept) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid && out_take) begin
      out_prio  <= skid_prio;
      out_owner <= skid_owner;
      out_cnt   <= skid_cnt;
      out_eor   <= skid_eor;
    end else if (accept && out_valid && !res.ready) begin
      skid_prio  <= prio_next;
      skid_owner <= owner_next;
      skid_cnt   <= cnt_next;
      skid_eor   <= req.last;
    end else if (accept) begin
      out_prio  <= prio_next;
      out_owner <= owner_next;
      out_cnt   <= cnt_next;
      out_eor   <= req.last;
    end
  end

  assign res.valid          = out_valid;
  assign res.new_priority   = out_prio;
  assign res.new_owner      = out_owner;
  assign res.distinct_count = out_cnt;
  assign res.end_of_run     = out_eor;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while output register is empty");

  a_prio_capped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, out_prio} <= PRIO_CAP))
    else $error("new priority above cap");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_cnt != '0))
    else $error("distinct count zero on a valid result");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && req.last) |=> (!started && distinct_counter == '0))
    else $error("run state not cleared after last request");

  a_first_count_one: assert property (@(posedge clk) disable iff (rst)
    (accept && !started) |=> (started || $past(req.last)))
    else $error("first request did not start a run");

endmodule
